@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int Capacity = 64;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeyW     = 32;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef logic signed [KeyW-1:0] key_t;

  // Compare result of a stored key against the item key.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

@@ rtl/sorted_key_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Sorted table of signed 32-bit keys with binary search, insert and delete.
// ----------------------------------------------------------------------------
// Pulse start_i with an opcode and a key while busy_o is low; exactly one
// result comes back on status_o, position_o and entry_count_o, valid for the
// single cycle in which done_o is high. The receiver cannot hold a result off,
// so sample it on that cycle. All work runs through one key memory with one
// read and one write port and one shared comparator, so the work per item
// depends on the operation: clear, insert into a full or an empty table and
// search or delete on an empty table finish straight from idle; search runs an
// address and a compare step per probe (at most 7 probes for 64 entries); any
// other insert moves each larger key up one place, from the top, and then
// writes the new key; delete runs the search and then moves each later key down
// one place. done_o rises the cycle after the last step, and busy_o is already
// low then, so the next item may start in that cycle.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                opcode_i,
  input  logic signed [31:0]        key_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [skt_pkg::AddrW-1:0] position_o,
  output logic [skt_pkg::CntW-1:0]  entry_count_o
);
  import skt_pkg::*;

  typedef logic signed [CntW:0] sidx_t;
  typedef logic        [CntW:0] ext_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_S_ADDR  = 6'b000010,
    ST_S_CMP   = 6'b000100,
    ST_D_SHIFT = 6'b001000,
    ST_I_SHIFT = 6'b010000,
    ST_I_PLACE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  key_t                key_q, key_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  sidx_t               lo_q, lo_d, hi_q, hi_d;
  logic [AddrW-1:0]    mid_q, mid_d;
  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [AddrW-1:0]    pos_q, pos_d;

  // memory and comparator hookup
  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  key_t                wdata, rdata;
  cmp_t                cmp;

  sidx_t               mid_sum, lo_n, hi_n;

  skt_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  skt_cmp u_cmp (
    .stored_i (rdata),
    .key_i    (key_q),
    .cmp_o    (cmp)
  );

  assign mid_sum = lo_q + hi_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    ptr_d    = ptr_q;
    done_d   = 1'b0;
    status_d = status_q;
    pos_d    = pos_q;
    we       = 1'b0;
    waddr    = ptr_q;
    wdata    = key_q;
    raddr    = '0;
    lo_n     = lo_q;
    hi_n     = hi_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d  = op_e'(opcode_i);
          key_d = key_i;
          case (op_e'(opcode_i))
            OP_CLEAR: begin
              // drop all entries; stored keys stay but are no longer valid
              cnt_d    = '0;
              done_d   = 1'b1;
              status_d = STAT_OK;
              pos_d    = '0;
            end
            OP_INSERT: begin
              if (cnt_q >= CntW'(Capacity)) begin
                done_d   = 1'b1;
                status_d = STAT_FULL;
                pos_d    = '0;
              end else if (cnt_q == '0) begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = key_i;
                cnt_d    = CntW'(1);
                done_d   = 1'b1;
                status_d = STAT_OK;
                pos_d    = '0;
              end else begin
                // walk down from the top, reading the last valid entry first
                ptr_d   = cnt_q[AddrW-1:0];
                raddr   = AddrW'(cnt_q - CntW'(1));
                state_d = ST_I_SHIFT;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_MISS;
                pos_d    = '0;
              end else begin
                lo_d    = '0;
                hi_d    = sidx_t'({1'b0, cnt_q}) - sidx_t'(1);
                state_d = ST_S_ADDR;
              end
            end
          endcase
        end
      end

      ST_S_ADDR: begin
        // probe floor((lo + hi) / 2)
        raddr   = mid_sum[AddrW:1];
        mid_d   = mid_sum[AddrW:1];
        state_d = ST_S_CMP;
      end

      ST_S_CMP: begin
        if (cmp.eq) begin
          if (op_q == OP_DELETE) begin
            ptr_d = mid_q;
            if (ext_t'(mid_q) + ext_t'(1) < ext_t'(cnt_q)) begin
              raddr   = mid_q + AddrW'(1);
              state_d = ST_D_SHIFT;
            end else begin
              cnt_d    = cnt_q - CntW'(1);
              done_d   = 1'b1;
              status_d = STAT_OK;
              pos_d    = mid_q;
              state_d  = ST_IDLE;
            end
          end else begin
            done_d   = 1'b1;
            status_d = STAT_OK;
            pos_d    = mid_q;
            state_d  = ST_IDLE;
          end
        end else begin
          if (cmp.gt) begin
            hi_n = sidx_t'({1'b0, mid_q}) - sidx_t'(1);
          end else begin
            lo_n = sidx_t'({1'b0, mid_q}) + sidx_t'(1);
          end
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n > hi_n) begin
            done_d   = 1'b1;
            status_d = STAT_MISS;
            pos_d    = '0;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_S_ADDR;
          end
        end
      end

      ST_D_SHIFT: begin
        // move entry ptr+1 down to ptr, prefetch ptr+2
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata;
        ptr_d = ptr_q + AddrW'(1);
        if (ext_t'(ptr_q) + ext_t'(2) < ext_t'(cnt_q)) begin
          raddr = ptr_q + AddrW'(2);
        end else begin
          cnt_d    = cnt_q - CntW'(1);
          done_d   = 1'b1;
          status_d = STAT_OK;
          pos_d    = mid_q;
          state_d  = ST_IDLE;
        end
      end

      ST_I_SHIFT: begin
        // rdata holds entry ptr-1
        we    = 1'b1;
        waddr = ptr_q;
        if (cmp.gt) begin
          wdata = rdata;
          ptr_d = ptr_q - AddrW'(1);
          if (ptr_q == AddrW'(1)) begin
            state_d = ST_I_PLACE;
          end else begin
            raddr = ptr_q - AddrW'(2);
          end
        end else begin
          wdata    = key_q;
          cnt_d    = cnt_q + CntW'(1);
          done_d   = 1'b1;
          status_d = STAT_OK;
          pos_d    = ptr_q;
          state_d  = ST_IDLE;
        end
      end

      ST_I_PLACE: begin
        we       = 1'b1;
        waddr    = ptr_q;
        wdata    = key_q;
        cnt_d    = cnt_q + CntW'(1);
        done_d   = 1'b1;
        status_d = STAT_OK;
        pos_d    = ptr_q;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = cnt_q;

  // a result is only shown once the sequencer has gone back to idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while sequencer busy");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_full_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> entry_count_o == CntW'(Capacity))
    else $error("full status with table not full");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_CLEAR) |=>
      (done_o && entry_count_o == '0 && status_o == STAT_OK))
    else $error("clear did not empty the table");

endmodule

@@ rtl/skt_store.sv @@
// ----------------------------------------------------------------------------
// skt_store
// Key memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [skt_pkg::AddrW-1:0] waddr_i,
  input  skt_pkg::key_t           wdata_i,
  input  logic [skt_pkg::AddrW-1:0] raddr_i,
  output skt_pkg::key_t           rdata_o
);
  import skt_pkg::*;

  key_t mem [Capacity];
  key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/skt_cmp.sv @@
// ----------------------------------------------------------------------------
// skt_cmp
// Shared signed key comparator used by search and insert.
// ----------------------------------------------------------------------------
module skt_cmp (
  input  skt_pkg::key_t stored_i,
  input  skt_pkg::key_t key_i,
  output skt_pkg::cmp_t cmp_o
);
  import skt_pkg::*;

  assign cmp_o.eq = (stored_i == key_i);
  assign cmp_o.gt = (stored_i > key_i);

endmodule

@@ tb/skt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker
// Watches the sorted key table ports, predicts each result and compares it.
// ----------------------------------------------------------------------------
module skt_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  opcode_i,
  input  skt_pkg::key_t               key_i,
  input  logic                        busy_i,
  input  logic                        done_i,
  input  logic [1:0]                  status_i,
  input  logic [skt_pkg::AddrW-1:0]   position_i,
  input  logic [skt_pkg::CntW-1:0]    entry_count_i,
  output int                          err_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  import skt_pkg::*;

  typedef struct {
    status_e            status;
    logic [AddrW-1:0]   position;
    logic [CntW-1:0]    count;
  } outcome_t;

  key_t      table_keys [Capacity];
  int        table_count;
  outcome_t  expected_outcomes [$];
  outcome_t  head;

  // Binary search with floor midpoint; first equal probe wins.
  function automatic int find_key(key_t k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = table_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_keys[mid] == k) return mid;
      if (table_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_op(op_e op, key_t k);
    outcome_t res;
    int       idx;
    res.status   = STAT_OK;
    res.position = '0;
    case (op)
      OP_SEARCH: begin
        idx = find_key(k);
        if (idx < 0) res.status = STAT_MISS;
        else res.position = AddrW'(idx);
      end
      OP_INSERT: begin
        if (table_count >= Capacity) begin
          res.status = STAT_FULL;
        end else begin
          // shift larger keys up; equal keys stay ahead of the new one
          idx = table_count;
          while (idx > 0 && table_keys[idx-1] > k) begin
            table_keys[idx] = table_keys[idx-1];
            idx--;
          end
          table_keys[idx] = k;
          table_count++;
          res.position = AddrW'(idx);
        end
      end
      OP_DELETE: begin
        idx = find_key(k);
        if (idx < 0) begin
          res.status = STAT_MISS;
        end else begin
          for (int j = idx; j + 1 < table_count; j++) table_keys[j] = table_keys[j+1];
          table_count--;
          res.position = AddrW'(idx);
        end
      end
      default: begin
        table_count = 0;
      end
    endcase
    res.count = CntW'(table_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count = 0;
      expected_outcomes.delete();
    end else begin
      if (start_i && !busy_i) begin
        expected_outcomes.push_back(apply_op(op_e'(opcode_i), key_i));
      end
      if (done_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no item outstanding: status %0d position %0d count %0d",
                 status_i, position_i, entry_count_i);
          err_count_o++;
        end else begin
          head = expected_outcomes.pop_front();
          checked_o++;
          if (head.status !== status_i) begin
            $error("status: expected %0d, actual %0d", head.status, status_i);
            err_count_o++;
          end
          if (head.position !== position_i) begin
            $error("position: expected %0d, actual %0d", head.position, position_i);
            err_count_o++;
          end
          if (head.count !== entry_count_i) begin
            $error("entry_count: expected %0d, actual %0d", head.count, entry_count_i);
            err_count_o++;
          end
        end
      end
    end
    pending_o = expected_outcomes.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted key table core.
// ----------------------------------------------------------------------------
// A short directed pass hits the empty table, the key extremes, duplicates,
// misses and clear. Random phases then fill the table to capacity, mix all
// operations and drain it again, with keys drawn from recent inserts, a small
// pool and the full 32-bit range. A side checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import skt_pkg::*;

  localparam int   NumRandom = 1330;
  localparam int   PhaseLen  = 110;
  localparam int   QuietTail = 150;
  localparam int   RecentN   = 16;
  localparam key_t KeyMin    = key_t'(32'h8000_0000);
  localparam key_t KeyMax    = key_t'(32'h7fff_ffff);

  typedef enum int {
    MODE_FILL,
    MODE_MIX,
    MODE_DRAIN
  } mode_e;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic [1:0]         opcode;
  key_t               key;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic [AddrW-1:0]   position;
  logic [CntW-1:0]    entry_count;

  int                 err_count;
  int                 pending;
  int                 checked;

  // Recently inserted keys: reuse them so searches and deletes hit.
  key_t               recent_keys [RecentN];
  int                 recent_wr;
  int                 op_sent [4];

  sorted_key_table_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .opcode_i      (opcode),
    .key_i         (key),
    .busy_o        (busy),
    .done_o        (done),
    .status_o      (status),
    .position_o    (position),
    .entry_count_o (entry_count)
  );

  skt_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .opcode_i      (opcode),
    .key_i         (key),
    .busy_i        (busy),
    .done_i        (done),
    .status_i      (status),
    .position_i    (position),
    .entry_count_i (entry_count),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold the item on the ports until an edge with busy low takes it,
  // then return at the following falling edge.
  task automatic send_item(op_e op, key_t k);
    start  <= 1'b1;
    opcode <= op;
    key    <= k;
    do @(posedge clk); while (busy);
    @(negedge clk);
    op_sent[int'(op)]++;
    if (op == OP_INSERT) begin
      recent_keys[recent_wr] = k;
      recent_wr = (recent_wr + 1) % RecentN;
    end
  endtask

  // Drop start for the given number of cycles; put noise on the payload meanwhile.
  task automatic idle_burst(int cycles);
    start  <= 1'b0;
    opcode <= 2'($urandom_range(0, 3));
    key    <= $urandom();
    repeat (cycles) @(negedge clk);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic key_t pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return recent_keys[$urandom_range(0, RecentN - 1)];
    if (sel < 65) return key_t'($urandom_range(0, 8)) - key_t'(4);
    if (sel < 75) begin
      case ($urandom_range(0, 5))
        0:       return KeyMin;
        1:       return KeyMax;
        2:       return key_t'(0);
        3:       return key_t'(-1);
        4:       return KeyMin + key_t'(1);
        default: return KeyMax - key_t'(1);
      endcase
    end
    return key_t'($urandom());
  endfunction

  // Weight the operations by phase: fill pushes into the full table,
  // drain empties it, mix exercises everything including clear.
  function automatic op_e pick_op(mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 85) return OP_INSERT;
        if (r < 95) return OP_SEARCH;
        return OP_DELETE;
      end
      MODE_MIX: begin
        if (r < 35) return OP_SEARCH;
        if (r < 70) return OP_INSERT;
        if (r < 97) return OP_DELETE;
        return OP_CLEAR;
      end
      default: begin
        if (r < 25) return OP_SEARCH;
        if (r < 40) return OP_INSERT;
        if (r < 99) return OP_DELETE;
        return OP_CLEAR;
      end
    endcase
  endfunction

  initial begin
    mode_e mode;
    bit    idle_on;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    opcode <= OP_SEARCH;
    key    <= '0;
    recent_wr = 0;
    for (int i = 0; i < 4; i++) op_sent[i] = 0;
    for (int i = 0; i < RecentN; i++) recent_keys[i] = key_t'($urandom());
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed: empty table, extremes, duplicates, misses, clear.
    send_item(OP_SEARCH, key_t'(5));
    send_item(OP_DELETE, key_t'(5));
    send_item(OP_INSERT, key_t'(0));
    send_item(OP_INSERT, KeyMax);
    send_item(OP_INSERT, KeyMin);
    send_item(OP_INSERT, key_t'(-1));
    send_item(OP_INSERT, key_t'(0));
    send_item(OP_INSERT, key_t'(0));
    send_item(OP_SEARCH, key_t'(0));
    send_item(OP_SEARCH, KeyMin);
    send_item(OP_SEARCH, KeyMax);
    send_item(OP_SEARCH, key_t'(-1));
    send_item(OP_SEARCH, key_t'(1));
    send_item(OP_DELETE, key_t'(0));
    send_item(OP_DELETE, KeyMax);
    send_item(OP_DELETE, key_t'(7));
    send_item(OP_DELETE, KeyMin);
    send_item(OP_INSERT, key_t'(1));
    send_item(OP_CLEAR,  key_t'(12345));
    send_item(OP_SEARCH, key_t'(0));
    send_item(OP_INSERT, key_t'(42));
    send_item(OP_SEARCH, key_t'(42));
    wait_drained();

    // Random phases; the first one fills the table past capacity.
    mode    = MODE_FILL;
    idle_on = 1'b1;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % PhaseLen == 0 && n != 0) begin
        mode    = mode_e'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 2) != 0);
      end
      // Pause once mid-run until the block has answered everything.
      if (n == NumRandom / 2) wait_drained();
      send_item(pick_op(mode), pick_key());
      if (idle_on && n < NumRandom - QuietTail && $urandom_range(0, 3) == 0) begin
        idle_burst($urandom_range(1, 4));
      end
    end

    // Let the last result land, then idle quietly before the summary.
    wait_drained();
    repeat (80) @(negedge clk);

    $display("Covered %0d searches, %0d inserts, %0d deletes, %0d clears in fill, mix and",
             op_sent[OP_SEARCH], op_sent[OP_INSERT], op_sent[OP_DELETE], op_sent[OP_CLEAR]);
    $display("drain phases; %0d results compared with the predicted table.", checked);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/skt_pkg.sv
rtl/skt_store.sv
rtl/skt_cmp.sv
rtl/sorted_key_table_core.sv
tb/skt_checker.sv
tb/tb.sv
